@@ rtl/core/poi_pkg.sv @@
`default_nettype none
package poi_pkg;

  localparam int ANGLE_WIDTH    = 16;
  localparam int POSITION_WIDTH = 48;
  localparam int CORDIC_STEPS   = 16;

  // turn scale is 8/(pi*1e6) in units of 2^-40, gain inverse is 0.60725293 in Q30
  localparam int TURN_SCALE   = 2799883;
  localparam int GAIN_INV_Q30 = 652032874;
  localparam int COEF_WIDTH   = 30;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [POSITION_WIDTH-1:0] pose_x;
    logic signed [POSITION_WIDTH-1:0] pose_y;
    logic signed [ANGLE_WIDTH-1:0]    heading;
  } out_item_t;

  // arctangent of 2^-i, 2^32 per full turn
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/planar_odometry_integrator_unit.sv @@
`default_nettype none
// Steps from an accepted transaction to out_valid: bit-serial speed/turn times
// time_step, bit-serial scaling by the turn and gain coefficients, a heading
// step, the CORDIC micro-rotations, and a round and saturate step. One
// transaction at a time: in_stall stays high until the result is registered
// at the output, which waits while an earlier result is still stalled there.
// Synchronous reset clears position, heading and all handshake state.
module planar_odometry_integrator_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire poi_pkg::in_item_t in_item,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      poi_pkg::out_item_t out_item
);
  import poi_pkg::*;

  localparam int AW     = ANGLE_WIDTH;
  localparam int PW     = POSITION_WIDTH;
  localparam int PROD_W = 32;
  localparam int ACC_W  = PROD_W + COEF_WIDTH;
  localparam int SH     = 56 - AW;
  localparam int IDX_W  = $clog2(CORDIC_STEPS);
  localparam int SUM_W  = ((PW > 34) ? PW : 34) + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((65'sd1 <<< (PW - 1)) - 65'sd1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< 29;

  typedef enum logic [5:0] {
    IDLE = 6'b000001,
    MUL1 = 6'b000010,
    MUL2 = 6'b000100,
    HEAD = 6'b001000,
    ROT  = 6'b010000,
    FIN  = 6'b100000
  } state_t;

  state_t state;
  logic [4:0] cnt;
  logic sign_w, sign_v;
  logic [15:0] dt_sr;
  logic [PROD_W-1:0] mw, mv, pw, pv;
  logic [COEF_WIDTH-1:0] kt, kg;
  logic [ACC_W-1:0] mtw, mtv, at, ad;
  logic [AW-1:0] heading_angle;
  logic signed [63:0] rx, ry;
  logic signed [31:0] rz;
  logic signed [PW-1:0] position_x, position_y;

  logic [PROD_W-1:0] pw_sum, pv_sum;
  logic [ACC_W-1:0] q;
  logic [AW-1:0] dang, hnew;
  logic fold;
  logic [31:0] theta;
  logic signed [63:0] x_start;
  logic [IDX_W-1:0] idx;
  logic signed [63:0] xs, ys;
  logic signed [31:0] atan_v;
  logic signed [63:0] rnd_x, rnd_y;
  logic signed [SUM_W-1:0] sum_x, sum_y, sat_x, sat_y;
  logic [16:0] mag_w, mag_v;

  assign in_stall = (state != IDLE);

  always_comb begin
    // magnitudes of the signed inputs
    mag_w = in_item.turn_rate[15] ? 17'(-$signed({1'b1, in_item.turn_rate}))
                                  : 17'(in_item.turn_rate);
    mag_v = in_item.linear_speed[15] ? 17'(-$signed({1'b1, in_item.linear_speed}))
                                     : 17'(in_item.linear_speed);
    pw_sum = pw + (dt_sr[0] ? mw : '0);
    pv_sum = pv + (dt_sr[0] ? mv : '0);
    // round turn to the angle lsb, half away from zero
    q     = (at + (ACC_W'(1) << (SH - 1))) >> SH;
    dang  = sign_w ? AW'(-q) : AW'(q);
    hnew  = heading_angle + dang;
    theta = {hnew, {(32 - AW){1'b0}}};
    fold  = hnew[AW-1] ^ hnew[AW-2];
    x_start = (sign_v ^ fold) ? -$signed(64'(ad)) : $signed(64'(ad));
    // one micro-rotation
    idx    = cnt[IDX_W-1:0];
    xs     = rx >>> idx;
    ys     = ry >>> idx;
    atan_v = $signed(atan_angle(5'(idx)));
    // round to nm and saturate
    rnd_x = (rx + ROUND_HALF) >>> 30;
    rnd_y = (ry + ROUND_HALF) >>> 30;
    sum_x = SUM_W'(position_x) + SUM_W'(rnd_x);
    sum_y = SUM_W'(position_y) + SUM_W'(rnd_y);
    priority if (sum_x > SUM_MAX) sat_x = SUM_MAX;
    else if (sum_x < SUM_MIN) sat_x = SUM_MIN;
    else sat_x = sum_x;
    priority if (sum_y > SUM_MAX) sat_y = SUM_MAX;
    else if (sum_y < SUM_MIN) sat_y = SUM_MIN;
    else sat_y = sum_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      heading_angle <= '0;
      position_x    <= '0;
      position_y    <= '0;
    end else begin
      // raise valid on a new result, drop it once taken
      if (state == FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            sign_w <= in_item.turn_rate[15];
            sign_v <= in_item.linear_speed[15];
            mw     <= PROD_W'(mag_w);
            mv     <= PROD_W'(mag_v);
            pw     <= '0;
            pv     <= '0;
            dt_sr  <= in_item.time_step;
            cnt    <= '0;
            state  <= MUL1;
          end
        end
        MUL1: begin
          // one bit of time_step per cycle
          pw    <= pw_sum;
          pv    <= pv_sum;
          mw    <= mw << 1;
          mv    <= mv << 1;
          dt_sr <= dt_sr >> 1;
          if (cnt == 5'd15) begin
            mtw   <= ACC_W'(pw_sum);
            mtv   <= ACC_W'(pv_sum);
            at    <= '0;
            ad    <= '0;
            kt    <= COEF_WIDTH'(TURN_SCALE);
            kg    <= COEF_WIDTH'(GAIN_INV_Q30);
            cnt   <= '0;
            state <= MUL2;
          end else begin
            cnt   <= cnt + 5'd1;
          end
        end
        MUL2: begin
          // one coefficient bit per cycle
          at  <= at + (kt[0] ? mtw : '0);
          ad  <= ad + (kg[0] ? mtv : '0);
          mtw <= mtw << 1;
          mtv <= mtv << 1;
          kt  <= kt >> 1;
          kg  <= kg >> 1;
          if (cnt == 5'(COEF_WIDTH - 1)) begin
            cnt   <= '0;
            state <= HEAD;
          end else begin
            cnt   <= cnt + 5'd1;
          end
        end
        HEAD: begin
          // turn heading, fold into the right half plane
          heading_angle <= hnew;
          rx    <= x_start;
          ry    <= '0;
          rz    <= $signed({theta[31] ^ fold, theta[30:0]});
          state <= ROT;
        end
        ROT: begin
          if (!rz[31]) begin
            rx <= rx - ys;
            ry <= ry + xs;
            rz <= rz - atan_v;
          end else begin
            rx <= rx + ys;
            ry <= ry - xs;
            rz <= rz + atan_v;
          end
          if (cnt == 5'(CORDIC_STEPS - 1)) begin
            cnt   <= '0;
            state <= FIN;
          end else begin
            cnt   <= cnt + 5'd1;
          end
        end
        FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            position_x       <= PW'(sat_x);
            position_y       <= PW'(sat_y);
            out_item.pose_x  <= PW'(sat_x);
            out_item.pose_y  <= PW'(sat_y);
            out_item.heading <= heading_angle;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/planar_odometry_integrator_unit_tb.sv @@
`default_nettype none
module planar_odometry_integrator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import poi_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam longint POS_MAX = (64'sd1 <<< (POSITION_WIDTH - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  planar_odometry_integrator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // predicted pose and the poses still owed by the block
  longint track_x;
  longint track_y;
  logic [ANGLE_WIDTH-1:0] track_heading;
  out_item_t pose_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int fail_count;
  int sent_count;
  int checked_count;
  int idle_cycles;

  typedef struct {
    in_item_t stim;
    bit known;
    out_item_t pose;
  } vector_t;

  vector_t vectors[] = '{
    // after reset and with zero steps the pose stays at the origin
    '{'{16'sd0, 16'sd0, 16'd0}, 1'b1, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sh7fff, 16'd0}, 1'b1, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sh8000, 16'd0}, 1'b1, '{48'sd0, 48'sd0, 16'sd0}},
    // turn too small to move the heading, no speed
    '{'{16'sd0, 16'sd1, 16'd1}, 1'b1, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd1000, 16'sd0, 16'd1000}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sd0, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sd0, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sh8000, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh8000, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh7fff, 16'sh8000, 16'd1}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{-16'sd1, -16'sd1, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sh5555, 16'sh5555, 16'h5555}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'shaaaa, 16'shaaaa, 16'haaaa}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    // keep turning at full rate so the heading wraps past a half turn
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{16'sd500, 16'sh7fff, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{-16'sd300, 16'sh8000, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}},
    '{'{-16'sd300, 16'sh8000, 16'hffff}, 1'b0, '{48'sd0, 48'sd0, 16'sd0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // heading increment for one transaction, rounded half away from zero
  function automatic logic [ANGLE_WIDTH-1:0] turn_increment(logic signed [15:0] rate,
                                                             logic [15:0] dt);
    longint prod;
    longint mag;
    longint q;
    prod = longint'(rate) * longint'({1'b0, dt}) * longint'(TURN_SCALE);
    mag = (prod < 0) ? -prod : prod;
    q = (mag + (64'sd1 <<< (55 - ANGLE_WIDTH))) >>> (56 - ANGLE_WIDTH);
    return (prod < 0) ? ANGLE_WIDTH'(-q) : ANGLE_WIDTH'(q);
  endfunction

  function automatic longint clamp_add(longint p, longint d);
    if (d > 0 && p > POS_MAX - d) return POS_MAX;
    if (d < 0 && p < POS_MIN - d) return POS_MIN;
    return p + d;
  endfunction

  // advance the tracked pose by one transaction and return the pose it reports
  function automatic out_item_t advance_pose(in_item_t it);
    logic [31:0] theta;
    longint travel;
    longint cx;
    longint cy;
    longint z;
    longint xs;
    longint ys;
    out_item_t r;
    track_heading = track_heading + turn_increment(it.turn_rate, it.time_step);
    travel = longint'(it.linear_speed) * longint'({1'b0, it.time_step});
    cx = travel * longint'(GAIN_INV_Q30);
    cy = 0;
    theta = {track_heading, {(32 - ANGLE_WIDTH){1'b0}}};
    // fold the left half plane by a half turn
    if (((theta + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      theta = theta + 32'h8000_0000;
      cx = -cx;
    end
    z = longint'(signed'(theta));
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - longint'(atan_angle(5'(i)));
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + longint'(atan_angle(5'(i)));
      end
    end
    cx = (cx + (64'sd1 <<< 29)) >>> 30;
    cy = (cy + (64'sd1 <<< 29)) >>> 30;
    track_x = clamp_add(track_x, cx);
    track_y = clamp_add(track_y, cy);
    r.pose_x = track_x[POSITION_WIDTH-1:0];
    r.pose_y = track_y[POSITION_WIDTH-1:0];
    r.heading = track_heading;
    return r;
  endfunction

  // predict each accepted transaction; directed rows with a typed pose must agree
  always @(posedge clk) begin
    out_item_t pred;
    if (!rst && in_valid && !in_stall) begin
      pred = advance_pose(in_item);
      if (sent_count < vectors.size() && vectors[sent_count].known &&
          pred !== vectors[sent_count].pose) begin
        $error("row %0d pose expected %p actual %p", sent_count,
               vectors[sent_count].pose, pred);
        fail_count++;
      end
      pose_q.push_back(pred);
      sent_count++;
    end
  end

  // check each accepted result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d heading=%0d",
               out_item.pose_x, out_item.pose_y, out_item.heading);
        fail_count++;
      end else begin
        want = pose_q.pop_front();
        checked_count++;
        if (out_item.pose_x !== want.pose_x) begin
          $error("pose_x expected %0d actual %0d", want.pose_x, out_item.pose_x);
          fail_count++;
        end
        if (out_item.pose_y !== want.pose_y) begin
          $error("pose_y expected %0d actual %0d", want.pose_y, out_item.pose_y);
          fail_count++;
        end
        if (out_item.heading !== want.heading) begin
          $error("heading expected %0d actual %0d", want.heading, out_item.heading);
          fail_count++;
        end
      end
    end
  end

  // drive the result stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL planar_odometry_integrator_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one transaction, with random gaps ahead of it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the input until every owed pose has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it = in_item_t'(48'({$urandom, $urandom}));
    case ($urandom_range(7))
      0: it.time_step = 16'd0;
      1: it.time_step = 16'hffff;
      2: it.time_step = 16'($urandom_range(255));
      3: it.linear_speed = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      4: it.turn_rate = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    int pct_sets[4][2];
    pct_sets = '{'{0, 0}, '{52, 0}, '{0, 52}, '{38, 38}};
    track_x = 0;
    track_y = 0;
    track_heading = '0;
    fail_count = 0;
    sent_count = 0;
    checked_count = 0;
    hold_ask = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, checked by the predictor as they are accepted
    foreach (vectors[i]) begin
      send_item(vectors[i].stim);
    end
    drain();

    // random traffic under each idling mix
    foreach (pct_sets[p]) begin
      send_idle_pct = pct_sets[p][0];
      recv_stall_pct = pct_sets[p][1];
      for (int n = 0; n < 400; n++) begin
        if (p == 0 && n == 100) hold_ask++;
        if (n == 200) drain();
        send_item(random_item());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transactions, %0d poses checked", sent_count, checked_count);
    $display("idling mixes, a long output hold-off, zero steps and heading wraps");
    if (fail_count == 0 && pose_q.size() == 0) begin
      $display("PASS planar_odometry_integrator_unit");
    end else begin
      $display("FAIL planar_odometry_integrator_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
